>>> src/hhms_pkg.sv
// Heading-hold motion sequencer: shared types and constants.
// No dependencies; used by every module of the block.
package hhms_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HEADING_BAND = 2'd0,
        CFG_BOOST        = 2'd1,
        CFG_MAX_DIST     = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        logic [11:0] heading_band;
        logic [7:0]  boost;
        logic [8:0]  max_distance_cm;
    } cfg_t;

    localparam logic [11:0] BAND_RST = 12'd32;
    localparam logic [7:0]  BOOST_RST = 8'd50;
    localparam logic [8:0]  MAX_DIST_RST = 9'd200;

    typedef enum logic [2:0] {
        OP_END    = 3'd0,
        OP_FWD    = 3'd1,
        OP_BACK   = 3'd2,
        OP_TURN_R = 3'd3,
        OP_TURN_L = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_RUNNING = 3'd1,
        ST_DONE    = 3'd2,
        ST_OBST    = 3'd3,
        ST_END     = 3'd4
    } status_t;

    typedef enum logic [6:0] {
        MODE_IDLE   = 7'b0000001,
        MODE_FWD    = 7'b0000010,
        MODE_TURN_R = 7'b0000100,
        MODE_TURN_L = 7'b0001000,
        MODE_DONE   = 7'b0010000,
        MODE_OBST   = 7'b0100000,
        MODE_END    = 7'b1000000
    } mode_t;

    localparam logic ACT_LOAD = 1'b0;

    typedef struct packed {
        logic [7:0] left_pwm;
        logic [7:0] right_pwm;
        logic [2:0] status;
    } result_t;

endpackage

>>> src/hhms_cfg.sv
// Heading-hold motion sequencer: configuration register file.
// Depends on hhms_pkg.
module hhms_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hhms_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [hhms_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output hhms_pkg::cfg_t                  cfg
);

    hhms_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heading_band    <= hhms_pkg::BAND_RST;
            cfg_reg.boost           <= hhms_pkg::BOOST_RST;
            cfg_reg.max_distance_cm <= hhms_pkg::MAX_DIST_RST;
        end
        else if (cfg_we)
        begin
            case (hhms_pkg::cfg_addr_t'(cfg_addr))
                hhms_pkg::CFG_HEADING_BAND: cfg_reg.heading_band <= cfg_wdata;
                hhms_pkg::CFG_BOOST:        cfg_reg.boost <= cfg_wdata[7:0];
                hhms_pkg::CFG_MAX_DIST:     cfg_reg.max_distance_cm <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/hhms_step.sv
// Heading-hold motion sequencer: motion state and per-request update logic.
// Depends on hhms_pkg.
module hhms_step #(
    parameter int HEADING_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  hhms_pkg::cfg_t                  cfg,
    input  logic                            action,
    input  logic [2:0]                      opcode,
    input  logic [7:0]                      arg_amount,
    input  logic [7:0]                      arg_speed,
    input  logic signed [HEADING_WIDTH-1:0] heading,
    input  logic [8:0]                      distance_cm,
    input  logic [7:0]                      now_seconds,
    output hhms_pkg::result_t               result
);

    localparam int RW = HEADING_WIDTH + 1;
    localparam int CW = HEADING_WIDTH + 2;

    hhms_pkg::mode_t    mode_reg, mode_next;
    logic signed [RW-1:0] ref_reg, ref_next;
    logic [7:0] base_reg, base_next;
    logic [7:0] secs_reg, secs_next;
    logic [7:0] start_reg, start_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] right_reg, right_next;

    logic signed [RW-1:0] head_r;
    logic signed [RW-1:0] turn_off;
    logic signed [CW-1:0] head_c, ref_c, band_c;
    logic [8:0] boost_sum;
    logic [7:0] boosted;
    logic [7:0] elapsed;
    logic       obstacle;

    always_comb
    begin
        head_r    = RW'(heading);
        turn_off  = RW'($signed({1'b0, arg_amount, 4'b0000}));
        head_c    = CW'(heading);
        ref_c     = CW'(ref_reg);
        band_c    = CW'($signed({1'b0, cfg.heading_band}));
        boost_sum = {1'b0, base_reg} + {1'b0, cfg.boost};
        boosted   = boost_sum[8] ? 8'hFF : boost_sum[7:0];
        elapsed   = now_seconds - start_reg;
        obstacle  = (distance_cm != 9'd0) && (distance_cm <= cfg.max_distance_cm);

        mode_next  = mode_reg;
        ref_next   = ref_reg;
        base_next  = base_reg;
        secs_next  = secs_reg;
        start_next = start_reg;
        left_next  = left_reg;
        right_next = right_reg;

        if (action == hhms_pkg::ACT_LOAD)
        begin
            base_next  = arg_speed;
            secs_next  = arg_amount;
            start_next = now_seconds;
            ref_next   = head_r;
            left_next  = 8'd0;
            right_next = 8'd0;
            case (hhms_pkg::opcode_t'(opcode))
                hhms_pkg::OP_END:
                    mode_next = hhms_pkg::MODE_END;
                hhms_pkg::OP_FWD:
                begin
                    mode_next  = hhms_pkg::MODE_FWD;
                    left_next  = arg_speed;
                    right_next = arg_speed;
                end
                hhms_pkg::OP_TURN_R:
                begin
                    mode_next = hhms_pkg::MODE_TURN_R;
                    ref_next  = head_r - turn_off;
                    left_next = arg_speed;
                end
                hhms_pkg::OP_TURN_L:
                begin
                    mode_next  = hhms_pkg::MODE_TURN_L;
                    ref_next   = head_r + turn_off;
                    right_next = arg_speed;
                end
                default:
                    mode_next = hhms_pkg::MODE_DONE;
            endcase
        end
        else
        begin
            case (mode_reg)
                hhms_pkg::MODE_FWD:
                begin
                    if (obstacle)
                    begin
                        mode_next  = hhms_pkg::MODE_OBST;
                        left_next  = 8'd0;
                        right_next = 8'd0;
                    end
                    else
                    begin
                        if (head_c < ref_c - band_c)
                            right_next = boosted;
                        else if (head_c > ref_c + band_c)
                            left_next = boosted;
                        else
                        begin
                            left_next  = base_reg;
                            right_next = base_reg;
                        end
                        if (elapsed >= secs_reg)
                        begin
                            mode_next  = hhms_pkg::MODE_DONE;
                            left_next  = 8'd0;
                            right_next = 8'd0;
                        end
                    end
                end
                hhms_pkg::MODE_TURN_R:
                begin
                    if (!(head_c > ref_c))
                    begin
                        mode_next  = hhms_pkg::MODE_DONE;
                        left_next  = 8'd0;
                        right_next = 8'd0;
                    end
                end
                hhms_pkg::MODE_TURN_L:
                begin
                    if (!(head_c < ref_c))
                    begin
                        mode_next  = hhms_pkg::MODE_DONE;
                        left_next  = 8'd0;
                        right_next = 8'd0;
                    end
                end
                default: ;
            endcase
        end

        result.left_pwm  = left_next;
        result.right_pwm = right_next;
        case (mode_next)
            hhms_pkg::MODE_FWD,
            hhms_pkg::MODE_TURN_R,
            hhms_pkg::MODE_TURN_L: result.status = hhms_pkg::ST_RUNNING;
            hhms_pkg::MODE_DONE:   result.status = hhms_pkg::ST_DONE;
            hhms_pkg::MODE_OBST:   result.status = hhms_pkg::ST_OBST;
            hhms_pkg::MODE_END:    result.status = hhms_pkg::ST_END;
            default:               result.status = hhms_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= hhms_pkg::MODE_IDLE;
            ref_reg   <= '0;
            base_reg  <= '0;
            secs_reg  <= '0;
            start_reg <= '0;
            left_reg  <= '0;
            right_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            ref_reg   <= ref_next;
            base_reg  <= base_next;
            secs_reg  <= secs_next;
            start_reg <= start_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

endmodule

>>> src/heading_hold_motion_sequencer_core.sv
// Heading-hold motion sequencer top level: stream ports, input and result registers.
// A request passes through the input register, then the result register.
// Throughput: one request per cycle while m_axis_tready does not stall the result.
// Reset (rst_n, async, active low): idle mode, state cleared, config at defaults.
// Depends on hhms_pkg, hhms_cfg, hhms_step.
module heading_hold_motion_sequencer_core #(
    parameter int HEADING_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hhms_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [hhms_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // opcode, arg_amount, arg_speed, heading, distance_cm, now_seconds, zero pad
    input  logic [((HEADING_WIDTH+43)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // left_pwm, right_pwm, status, zero pad
    output logic [23:0]                     m_axis_tdata
);

    localparam int HW = HEADING_WIDTH;
    localparam int INW = ((HW + 43) / 8) * 8;

    hhms_pkg::cfg_t    cfg;
    hhms_pkg::result_t result;

    logic           in_valid_reg;
    logic [INW-1:0] in_data_reg;
    logic           in_user_reg;
    logic           out_valid_reg;
    hhms_pkg::result_t out_reg;
    logic           step_fire;
    logic           s_fire;

    assign step_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_data_reg <= s_axis_tdata;
            in_user_reg <= s_axis_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
            out_reg <= result;
    end

    hhms_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hhms_step #(
        .HEADING_WIDTH (HW)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (step_fire),
        .cfg         (cfg),
        .action      (in_user_reg),
        .opcode      (in_data_reg[2:0]),
        .arg_amount  (in_data_reg[10:3]),
        .arg_speed   (in_data_reg[18:11]),
        .heading     ($signed(in_data_reg[18+HW:19])),
        .distance_cm (in_data_reg[27+HW:19+HW]),
        .now_seconds (in_data_reg[35+HW:28+HW]),
        .result      (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.status, out_reg.right_pwm, out_reg.left_pwm};

    ap_idle_zero_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.status != hhms_pkg::ST_RUNNING)
        |-> (out_reg.left_pwm == 8'd0 && out_reg.right_pwm == 8'd0))
        else $error("pwm nonzero while no motion runs");

    ap_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> in_valid_reg)
        else $error("accepted request lost from input register");

    ap_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(step_fire))
        else $error("result appeared without a processed request");

    ap_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |=> in_valid_reg)
        else $error("pending request dropped under back-pressure");

endmodule

>>> bench/heading_hold_motion_sequencer_core_tb.sv
// Testbench for heading_hold_motion_sequencer_core: directed and random load/sample requests,
// with a scoreboard that predicts the PWM duties and status of every request.
// Depends on hhms_pkg and the RTL under src/.
`timescale 1ns / 1ps

module heading_hold_motion_sequencer_core_tb;

    localparam int HW = 24;
    localparam longint HEAD_MIN = -(longint'(1) << (HW - 1));
    localparam longint HEAD_MAX = (longint'(1) << (HW - 1)) - 1;

    typedef struct {
        logic [7:0]        left_pwm;
        logic [7:0]        right_pwm;
        hhms_pkg::status_t status;
    } duty_report_t;

    class motion_scoreboard;
        logic [11:0]     band;
        logic [7:0]      boost_amt;
        logic [8:0]      obst_range;
        hhms_pkg::mode_t mode;
        longint          ref_heading;
        logic [7:0]      base_speed;
        logic [7:0]      drive_secs;
        logic [7:0]      start_sec;
        logic [7:0]      left_duty;
        logic [7:0]      right_duty;
        duty_report_t    pending[$];
        int              fail_count;

        function new();
            band = hhms_pkg::BAND_RST;
            boost_amt = hhms_pkg::BOOST_RST;
            obst_range = hhms_pkg::MAX_DIST_RST;
            mode = hhms_pkg::MODE_IDLE;
            ref_heading = 0;
            base_speed = '0;
            drive_secs = '0;
            start_sec = '0;
            left_duty = '0;
            right_duty = '0;
            fail_count = 0;
        endfunction

        function void write_reg(hhms_pkg::cfg_addr_t addr, logic [11:0] value);
            case (addr)
                hhms_pkg::CFG_HEADING_BAND: band = value;
                hhms_pkg::CFG_BOOST:        boost_amt = value[7:0];
                hhms_pkg::CFG_MAX_DIST:     obst_range = value[8:0];
                default: ;
            endcase
        endfunction

        function void stop_drive(hhms_pkg::mode_t m);
            mode = m;
            left_duty = '0;
            right_duty = '0;
        endfunction

        function hhms_pkg::status_t status_of(hhms_pkg::mode_t m);
            case (m)
                hhms_pkg::MODE_FWD,
                hhms_pkg::MODE_TURN_R,
                hhms_pkg::MODE_TURN_L: return hhms_pkg::ST_RUNNING;
                hhms_pkg::MODE_DONE:   return hhms_pkg::ST_DONE;
                hhms_pkg::MODE_OBST:   return hhms_pkg::ST_OBST;
                hhms_pkg::MODE_END:    return hhms_pkg::ST_END;
                default:               return hhms_pkg::ST_IDLE;
            endcase
        endfunction

        function void note_request(logic act, logic [63:0] data);
            logic [2:0]   op;
            logic [7:0]   amt;
            logic [7:0]   spd;
            longint       head;
            logic [8:0]   dist_cm;
            logic [7:0]   now_s;
            logic [8:0]   sum;
            logic [7:0]   boosted;
            logic [7:0]   elapsed;
            duty_report_t rep;
            op = data[2:0];
            amt = data[10:3];
            spd = data[18:11];
            head = longint'($signed(data[42:19]));
            dist_cm = data[51:43];
            now_s = data[59:52];
            if (act == hhms_pkg::ACT_LOAD)
            begin
                base_speed = spd;
                drive_secs = amt;
                start_sec = now_s;
                ref_heading = head;
                case (op)
                    hhms_pkg::OP_END: stop_drive(hhms_pkg::MODE_END);
                    hhms_pkg::OP_FWD:
                    begin
                        mode = hhms_pkg::MODE_FWD;
                        left_duty = spd;
                        right_duty = spd;
                    end
                    hhms_pkg::OP_TURN_R:
                    begin
                        mode = hhms_pkg::MODE_TURN_R;
                        ref_heading = head - longint'(amt) * 16;
                        left_duty = spd;
                        right_duty = '0;
                    end
                    hhms_pkg::OP_TURN_L:
                    begin
                        mode = hhms_pkg::MODE_TURN_L;
                        ref_heading = head + longint'(amt) * 16;
                        left_duty = '0;
                        right_duty = spd;
                    end
                    default: stop_drive(hhms_pkg::MODE_DONE);
                endcase
            end
            else if (mode == hhms_pkg::MODE_FWD)
            begin
                if (dist_cm != 0 && dist_cm <= obst_range)
                begin
                    stop_drive(hhms_pkg::MODE_OBST);
                end
                else
                begin
                    sum = 9'(base_speed) + 9'(boost_amt);
                    boosted = (sum > 9'd255) ? 8'd255 : sum[7:0];
                    if (head < ref_heading - longint'(band))
                    begin
                        right_duty = boosted;
                    end
                    else if (head > ref_heading + longint'(band))
                    begin
                        left_duty = boosted;
                    end
                    else
                    begin
                        left_duty = base_speed;
                        right_duty = base_speed;
                    end
                    elapsed = now_s - start_sec;
                    if (elapsed >= drive_secs)
                        stop_drive(hhms_pkg::MODE_DONE);
                end
            end
            else if (mode == hhms_pkg::MODE_TURN_R)
            begin
                if (!(head > ref_heading))
                    stop_drive(hhms_pkg::MODE_DONE);
            end
            else if (mode == hhms_pkg::MODE_TURN_L)
            begin
                if (!(head < ref_heading))
                    stop_drive(hhms_pkg::MODE_DONE);
            end
            rep.left_pwm = left_duty;
            rep.right_pwm = right_duty;
            rep.status = status_of(mode);
            pending.push_back(rep);
        endfunction

        function void check_result(logic [23:0] data);
            duty_report_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result: left %0d right %0d status %0d",
                         $time, data[7:0], data[15:8], data[18:16]);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            if (data[7:0] !== want.left_pwm)
            begin
                $display("%0t left_pwm mismatch: expected %0d actual %0d",
                         $time, want.left_pwm, data[7:0]);
                fail_count++;
            end
            if (data[15:8] !== want.right_pwm)
            begin
                $display("%0t right_pwm mismatch: expected %0d actual %0d",
                         $time, want.right_pwm, data[15:8]);
                fail_count++;
            end
            if (data[18:16] !== want.status)
            begin
                $display("%0t status mismatch: expected %0d actual %0d",
                         $time, want.status, data[18:16]);
                fail_count++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    hhms_pkg::cfg_addr_t cfg_addr;
    logic [11:0]         cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata;
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [23:0]         m_axis_tdata;

    logic                stall_req;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  sent_count;
    int                  hold_left;

    motion_scoreboard sb = new();

    heading_hold_motion_sequencer_core #(
        .HEADING_WIDTH(HW)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // result side: random stalls, plus one long hold-off per stall request
    initial
    begin
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_req)
            begin
                hold_left = 80;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [23:0] clamp_heading(longint v);
        if (v < HEAD_MIN)
            return HEAD_MIN[23:0];
        if (v > HEAD_MAX)
            return HEAD_MAX[23:0];
        return v[23:0];
    endfunction

    task automatic send_fields(input logic act, input logic [2:0] op, input logic [7:0] amt,
                               input logic [7:0] spd, input logic [23:0] head,
                               input logic [8:0] dist_cm, input logic [7:0] now_s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {4'b0, now_s, dist_cm, head, spd, amt, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_noise();
        send_fields(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 8'($urandom()),
                    8'($urandom()), 24'($urandom()), 9'($urandom_range(0, 500)),
                    8'($urandom()));
    endtask

    function automatic logic [8:0] pick_distance();
        if ($urandom_range(0, 99) < 65)
            return 9'd0;
        return 9'($urandom_range(0, 500));
    endfunction

    // one load followed by a run of plausible sensor samples
    task automatic run_motion_program();
        int          pick;
        logic [2:0]  op;
        logic [7:0]  amt;
        logic [7:0]  now_s;
        longint      start_head;
        longint      cur_head;
        int          span;
        int          n_samples;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = hhms_pkg::OP_FWD;
        else if (pick < 65)
            op = hhms_pkg::OP_TURN_R;
        else if (pick < 85)
            op = hhms_pkg::OP_TURN_L;
        else if (pick < 90)
            op = hhms_pkg::OP_END;
        else if (pick < 95)
            op = hhms_pkg::OP_BACK;
        else
            op = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) == 0)
            start_head = longint'($signed(24'($urandom())));
        else
            start_head = longint'($urandom_range(0, 200000)) - 100000;
        if ($urandom_range(0, 9) == 0)
            amt = 8'($urandom());
        else if (op == hhms_pkg::OP_FWD)
            amt = 8'($urandom_range(0, 12));
        else
            amt = 8'($urandom_range(0, 30));
        now_s = 8'($urandom());
        send_fields(hhms_pkg::ACT_LOAD, op, amt, 8'($urandom()), clamp_heading(start_head),
                    pick_distance(), now_s);
        start_head = longint'($signed(clamp_heading(start_head)));
        cur_head = start_head;
        span = 3 * int'(sb.band) + 40;
        n_samples = $urandom_range(1, 10);
        repeat (n_samples)
        begin
            now_s = now_s + 8'($urandom_range(0, 2));
            if (op == hhms_pkg::OP_FWD)
                cur_head = start_head + longint'($urandom_range(0, 2 * span)) - span;
            else if (op == hhms_pkg::OP_TURN_R)
                cur_head = cur_head - longint'($urandom_range(0, amt * 16 / 3 + 16));
            else
                cur_head = cur_head + longint'($urandom_range(0, amt * 16 / 3 + 16));
            send_fields(1'b1, 3'($urandom()), 8'($urandom()), 8'($urandom()),
                        clamp_heading(cur_head), pick_distance(), now_s);
        end
    endtask

    task automatic directed_requests();
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'd0, 9'd0, 8'd0);
        // zero drive time at the top of the heading range
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_FWD, 8'd0, 8'd255, 24'h7FFFFF, 9'd0, 8'd0);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'h7FFFFF, 9'd0, 8'd0);
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_FWD, 8'd255, 8'd0, 24'h800000, 9'd0,
                    8'd250);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, clamp_heading(HEAD_MIN + 33), 9'd201,
                    8'd251);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'h800000, 9'd500, 8'd252);
        // boost saturates; the held wheel keeps its boosted duty
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_FWD, 8'd10, 8'd230, 24'd0, 9'd0, 8'd250);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, clamp_heading(-33), 9'd0, 8'd255);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'd33, 9'd0, 8'd2);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'd0, 9'd0, 8'd4);
        // obstacle right at the range limit and at 1 cm
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_FWD, 8'd100, 8'd100, 24'd0, 9'd0, 8'd0);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'd0, 9'd200, 8'd0);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'd0, 9'd0, 8'd1);
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_FWD, 8'd100, 8'd100, 24'd0, 9'd0, 8'd0);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'd0, 9'd1, 8'd0);
        // turns, including a load that replaces a running turn
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_TURN_R, 8'd255, 8'd255, 24'h800000, 9'd0,
                    8'd0);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'h800000, 9'd0, 8'd0);
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_TURN_L, 8'd255, 8'd7, 24'h7FFFFF, 9'd0,
                    8'd0);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'h7FFFFF, 9'd0, 8'd0);
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_TURN_R, 8'd10, 8'd90, 24'd0, 9'd0, 8'd0);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, clamp_heading(-159), 9'd0, 8'd0);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, clamp_heading(-160), 9'd0, 8'd0);
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_TURN_L, 8'd0, 8'd40, 24'd5, 9'd0, 8'd0);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'd5, 9'd0, 8'd0);
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_END, 8'd3, 8'd3, 24'd0, 9'd0, 8'd0);
        send_fields(1'b1, hhms_pkg::OP_END, 8'd0, 8'd0, 24'd0, 9'd0, 8'd0);
        send_fields(hhms_pkg::ACT_LOAD, hhms_pkg::OP_BACK, 8'd5, 8'd5, 24'd0, 9'd0, 8'd0);
        send_fields(hhms_pkg::ACT_LOAD, 3'd7, 8'd5, 8'd5, 24'd0, 9'd0, 8'd0);
        send_fields(hhms_pkg::ACT_LOAD, 3'd5, 8'd5, 8'd5, 24'd0, 9'd0, 8'd0);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_settings(input logic [11:0] band, input logic [7:0] boost_v,
                                  input logic [8:0] dist_cm);
        hhms_pkg::cfg_addr_t addrs[3];
        logic [11:0]         vals[3];
        addrs[0] = hhms_pkg::CFG_HEADING_BAND;
        addrs[1] = hhms_pkg::CFG_BOOST;
        addrs[2] = hhms_pkg::CFG_MAX_DIST;
        vals[0] = band;
        vals[1] = {4'b0, boost_v};
        vals[2] = {3'b0, dist_cm};
        for (int i = 0; i < 3; i++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= addrs[i];
            cfg_wdata <= vals[i];
            sb.write_reg(addrs[i], vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int phase_start;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = hhms_pkg::CFG_HEADING_BAND;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        stall_req = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 57;
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                1: write_settings(12'd4095, 8'd255, 9'd500);
                2: write_settings(12'd0, 8'd0, 9'd0);
                3: write_settings(12'($urandom_range(0, 200)), 8'($urandom()),
                                  9'($urandom_range(1, 500)));
                4: write_settings(12'd16, 8'd200, 9'd1);
                5: write_settings(12'($urandom_range(0, 4095)), 8'($urandom()),
                                  9'($urandom_range(0, 500)));
                default: ;
            endcase
            stall_req <= 1'b1;
            @(posedge clk);
            stall_req <= 1'b0;
            if (phase == 0)
                directed_requests();
            phase_start = sent_count;
            while (sent_count - phase_start < 80)
            begin
                if ($urandom_range(0, 99) < 15)
                    send_noise();
                else
                    run_motion_program();
            end
            drain_results();
        end

        if (sb.fail_count == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> heading_hold_motion_sequencer_core.f
src/hhms_pkg.sv
src/hhms_cfg.sv
src/hhms_step.sv
src/heading_hold_motion_sequencer_core.sv
bench/heading_hold_motion_sequencer_core_tb.sv
